/* src/bsort_pkg.sv */
// Shared types for the bitonic sorter: the controller phase and the per-cell control word.
`default_nettype none

package bsort_pkg;

    // Width of the step and distance codes carried to every cell.
    localparam int CTRL_W = 3;

    typedef enum logic [1:0] {
        PHASE_LOAD,
        PHASE_SORT,
        PHASE_EMIT
    } phase_t;

    typedef struct packed {
        logic              shift_en;
        logic              cmp_en;
        logic              asc;
        logic [CTRL_W-1:0] step;
        logic [CTRL_W-1:0] dist_log;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* src/bsort_cell.sv */
// One sorter cell: holds one element, shifts it along the row or compare-exchanges it.
`default_nettype none

module bsort_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int LOG_N      = 5,
    parameter int INDEX      = 0
) (
    input  wire                                 aclk,
    input  bsort_pkg::cell_ctrl_t               ctrl,
    input  wire [DATA_WIDTH-1:0]                shift_in,
    input  wire [LOG_N-1:0][DATA_WIDTH-1:0]     partners,
    output logic [DATA_WIDTH-1:0]               data_out
);

    localparam logic [LOG_N:0] IDX = (LOG_N+1)'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic [DATA_WIDTH-1:0] partner;
    logic                  is_hi;
    logic                  flip;
    logic                  up;
    logic                  take_partner;

    always_comb begin
        partner = partners[0];
        is_hi   = IDX[0];
        flip    = 1'b0;
        for (int k = 0; k < LOG_N; k++) begin
            if (ctrl.dist_log == bsort_pkg::CTRL_W'(k)) begin
                partner = partners[k];
                is_hi   = IDX[k];
            end
        end
        // The direction flips in odd blocks of the current step.
        for (int k = 1; k <= LOG_N; k++) begin
            if (ctrl.step == bsort_pkg::CTRL_W'(k - 1)) begin
                flip = IDX[k];
            end
        end
        up = ctrl.asc ^ flip;
        // The lower cell keeps the smaller value when sorting up, the upper one the larger.
        if (is_hi ^ ~up) begin
            take_partner = partner > data_reg;
        end else begin
            take_partner = partner < data_reg;
        end
        data_next = take_partner ? partner : data_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift_en) begin
            data_reg <= shift_in;
        end else if (ctrl.cmp_en) begin
            data_reg <= data_next;
        end
    end

    assign data_out = data_reg;

endmodule

`default_nettype wire

/* src/bitonic_sorter.sv */
// Top level of the bitonic sorter: cell row, load/sort/emit controller and channel ports.
`default_nettype none

// Channel   | Direction | Ports                                  | Beat
// ----------+-----------+----------------------------------------+---------------------------
// input     | in        | s_valid, s_ready, s_value              | one element of the set
// result    | out       | m_valid, m_ready, m_sorted_value, m_last| one sorted element
// config    | in        | cfg_wr_en, cfg_wr_data                 | sort order, 1 = ascending
//
// A set of N = 2**LOG_N elements is loaded, then sorted, then emitted. The cell row
// performs a single compare-exchange pass per cycle, one network stage each. Reset is
// synchronous and active low; it clears the controller and the order register, not the
// cell contents. A stall on m_ready holds the row; s_ready is high only while a set is
// being loaded.

module bitonic_sorter #(
    parameter int LOG_N      = 5,
    parameter int DATA_WIDTH = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire         cfg_wr_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [31:0] s_value,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [31:0] m_sorted_value,
    output logic        m_last
);

    localparam int N  = 1 << LOG_N;
    localparam int SW = $clog2(LOG_N + 1);

    // Controller state.
    bsort_pkg::phase_t phase_reg, phase_next;
    logic [LOG_N-1:0]  count_reg, count_next;
    logic [SW-1:0]     step_reg, step_next;
    logic [SW-1:0]     stage_reg, stage_next;
    logic              asc_reg;

    logic              in_beat;
    logic              out_beat;
    logic [SW-1:0]     dist_log;
    bsort_pkg::cell_ctrl_t ctrl;

    // Cell row data.
    logic [DATA_WIDTH-1:0]              cell_data [N];
    logic [DATA_WIDTH-1:0]              in_ext;
    logic [DATA_WIDTH+31:0]             in_wide;
    logic [DATA_WIDTH+31:0]             out_wide;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;
    assign dist_log = step_reg - stage_reg;

    // Input bits above DATA_WIDTH are dropped; narrow stores are zero-extended on output.
    assign in_wide  = {{DATA_WIDTH{1'b0}}, s_value};
    assign in_ext   = in_wide[DATA_WIDTH-1:0];
    assign out_wide = {32'd0, cell_data[0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            asc_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            asc_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= bsort_pkg::PHASE_LOAD;
            count_reg <= '0;
            step_reg  <= '0;
            stage_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            stage_reg <= stage_next;
        end
    end

    // Loading shifts each element down the row so that the first one ends in cell 0.
    // Sorting runs one network stage per cycle. Emitting shifts the row out through cell 0.
    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        step_next     = step_reg;
        stage_next    = stage_reg;
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        ctrl.shift_en = 1'b0;
        ctrl.cmp_en   = 1'b0;
        ctrl.asc      = asc_reg;
        ctrl.step     = bsort_pkg::CTRL_W'(step_reg);
        ctrl.dist_log = bsort_pkg::CTRL_W'(dist_log);
        unique case (phase_reg)
            bsort_pkg::PHASE_LOAD: begin
                s_ready       = 1'b1;
                ctrl.shift_en = s_valid;
                if (s_valid) begin
                    count_next = count_reg + 1'b1;
                    if (&count_reg) begin
                        phase_next = bsort_pkg::PHASE_SORT;
                        step_next  = '0;
                        stage_next = '0;
                    end
                end
            end
            bsort_pkg::PHASE_SORT: begin
                ctrl.cmp_en = 1'b1;
                if (stage_reg == step_reg) begin
                    stage_next = '0;
                    if (step_reg == SW'(LOG_N - 1)) begin
                        step_next  = '0;
                        phase_next = bsort_pkg::PHASE_EMIT;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end else begin
                    stage_next = stage_reg + 1'b1;
                end
            end
            bsort_pkg::PHASE_EMIT: begin
                m_valid       = 1'b1;
                ctrl.shift_en = m_ready;
                if (m_ready) begin
                    count_next = count_reg + 1'b1;
                    if (&count_reg) begin
                        phase_next = bsort_pkg::PHASE_LOAD;
                    end
                end
            end
            default: begin
                phase_next = bsort_pkg::PHASE_LOAD;
            end
        endcase
    end

    assign m_sorted_value = out_wide[31:0];
    assign m_last         = m_valid && (&count_reg);

    // The row of cells. Each cell sees its shift neighbor and its partner at every distance.
    for (genvar i = 0; i < N; i++) begin : g_cell
        logic [LOG_N-1:0][DATA_WIDTH-1:0] partners;
        logic [DATA_WIDTH-1:0]            shift_in;

        for (genvar k = 0; k < LOG_N; k++) begin : g_partner
            assign partners[k] = cell_data[i ^ (1 << k)];
        end

        if (i == N - 1) begin : g_top
            assign shift_in = in_ext;
        end else begin : g_mid
            assign shift_in = cell_data[i + 1];
        end

        bsort_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .LOG_N      (LOG_N),
            .INDEX      (i)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .shift_in (shift_in),
            .partners (partners),
            .data_out (cell_data[i])
        );
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result channels open at the same time");

    a_last_only_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_last |-> m_valid)
        else $error("last flag without a result beat");

    a_set_done_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_beat && m_last) |=> (s_ready && !m_valid))
        else $error("sorter did not return to loading after the final beat");

    a_load_done_sort: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && (&count_reg)) |=> (phase_reg == bsort_pkg::PHASE_SORT && !s_ready))
        else $error("full set did not start the sort");
`endif

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking testbench for bitonic_sorter: directed and random sets in both sort orders.
`timescale 1ns / 1ps

module tb_top;

    // The block is built at its default size. Every set is 32 elements, so a single sorted
    // result needs a whole set, and no set can be smaller than this.
    localparam int LOG_N        = 5;
    localparam int SET_SIZE     = 1 << LOG_N;
    // Idle wait after the last owed beat has come out, long enough for the block to settle
    // back into loading.
    localparam int DRAIN_CYCLES = 100;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_PCT     = 16;
    localparam int DIRECTED_SETS = 4;
    localparam int RANDOM_SETS  = 3;
    // The worst correct run is 7 sets with their order writes, drains and hold-off; this is
    // far beyond it.
    localparam int CYCLE_LIMIT  = 20000;

    localparam logic ORDER_DESC = 1'b0;
    localparam logic ORDER_ASC  = 1'b1;

    // How the elements of one set are made up.
    typedef enum logic [3:0] {
        FILL_CONST,
        FILL_RAMP_UP,
        FILL_RAMP_DOWN,
        FILL_EXTREMES,
        FILL_ONE_HOT,
        FILL_FEW_KEYS,
        FILL_RANDOM,
        FILL_NARROW,
        FILL_CORNERS
    } fill_t;

    // One row of the directed table: the sort order to run with, how the set is filled,
    // and whether the result is obvious enough to be typed in (every element equal).
    typedef struct packed {
        logic        order;
        fill_t       fill;
        logic [31:0] seed;
        logic        typed;
    } set_row_t;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
    } sorted_beat_t;

    set_row_t directed_sets [0:DIRECTED_SETS-1] = '{
        '{ORDER_ASC,  FILL_CONST,     32'h0000_0000, 1'b1},
        '{ORDER_DESC, FILL_CONST,     32'hFFFF_FFFF, 1'b1},
        '{ORDER_DESC, FILL_EXTREMES,  32'h0000_0000, 1'b0},
        '{ORDER_ASC,  FILL_RAMP_DOWN, 32'hFFFF_FFFF, 1'b0}
    };

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic        cfg_wr_data    = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [31:0] s_value        = 32'h0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [31:0] m_sorted_value;
    logic        m_last;

    // Predictor state: the order register as the block holds it, the set being gathered,
    // and the sorted beats still owed by the block.
    logic         model_asc = ORDER_ASC;
    logic [31:0]  gathered_set [SET_SIZE];
    int           gathered_count = 0;
    logic         typed_fill = 1'b0;
    logic [31:0]  typed_value = 32'h0;
    sorted_beat_t owed_beats [$];

    bit           no_idle = 1'b0;
    bit           long_hold_req = 1'b0;
    bit           long_hold_done = 1'b0;
    int           hold_left = 0;
    int           mismatch_count = 0;
    int           beat_count = 0;
    int           cycle_count = 0;

    always #10 aclk = ~aclk;

    bitonic_sorter #(
        .LOG_N      (LOG_N),
        .DATA_WIDTH (32)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_last         (m_last)
    );

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] wanted);
        $display("MISMATCH at beat %0d: %s: got %h, expected %h", beat_count, what, got,
                 wanted);
        mismatch_count++;
    endtask

    // Runs the full network on the gathered set in place. Within step s and stage st the
    // pairs lie 2**(s-st) apart, and a pair sorts against the configured order whenever
    // bit s of its pair index is set.
    function automatic void bitonic_network();
        int          gap;
        int          lo;
        int          hi;
        logic        up;
        logic [31:0] a;
        logic [31:0] b;
        for (int s = 0; s < LOG_N; s++) begin
            for (int st = 0; st <= s; st++) begin
                gap = 1 << (s - st);
                for (int p = 0; p < SET_SIZE / 2; p++) begin
                    lo = (p % gap) + (p / gap) * 2 * gap;
                    hi = lo + gap;
                    up = model_asc;
                    if (((p >> s) & 1) != 0) begin
                        up = ~up;
                    end
                    a = gathered_set[lo];
                    b = gathered_set[hi];
                    // Ascending pairs want the smaller value low; descending the larger.
                    if ((a > b) == up) begin
                        gathered_set[lo] = b;
                        gathered_set[hi] = a;
                    end
                end
            end
        end
    endfunction

    // Called for every accepted input beat. The beat that completes a set makes the
    // block owe a full set of sorted beats, the last one flagged.
    function automatic void gather_element(input logic [31:0] v);
        gathered_set[gathered_count] = v;
        gathered_count++;
        if (gathered_count == SET_SIZE) begin
            gathered_count = 0;
            if (!typed_fill) begin
                bitonic_network();
            end
            for (int i = 0; i < SET_SIZE; i++) begin
                owed_beats.push_back('{value: typed_fill ? typed_value : gathered_set[i],
                                       last:  (i == SET_SIZE - 1)});
            end
        end
    endfunction

    function automatic logic [31:0] element_for(input fill_t fill, input logic [31:0] seed,
                                                input int i);
        case (fill)
            FILL_CONST:     return seed;
            FILL_RAMP_UP:   return seed + i;
            FILL_RAMP_DOWN: return seed - i;
            FILL_EXTREMES:  return i[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
            // Walks a single one from the top bit down, so each bit is set once.
            FILL_ONE_HOT:   return 32'h8000_0000 >> i;
            // Four distinct keys, each eight times: plenty of ties.
            FILL_FEW_KEYS:  return seed ^ {30'b0, i[1:0]};
            FILL_NARROW:    return $urandom_range(7);
            FILL_CORNERS: begin
                case ($urandom_range(4))
                    0:       return 32'h0000_0000;
                    1:       return 32'hFFFF_FFFF;
                    2:       return 32'h7FFF_FFFF;
                    3:       return 32'h8000_0000;
                    default: return $urandom;
                endcase
            end
            default:        return $urandom;
        endcase
    endfunction

    // Offers one beat and returns at the falling edge after it was taken, with s_valid
    // still high, so that the next call either keeps it up or drops it while it idles.
    task automatic send_element(input logic [31:0] v);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        gather_element(v);
        @(negedge aclk);
    endtask

    task automatic send_set(input fill_t fill, input logic [31:0] seed);
        for (int i = 0; i < SET_SIZE; i++) begin
            send_element(element_for(fill, seed, i));
        end
    endtask

    // The order register is only written with the block idle: every owed beat has come
    // out and the block has had its full latency to settle back into loading.
    task automatic write_order(input logic order);
        s_valid <= 1'b0;
        while (owed_beats.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= order;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        model_asc = order;
    endtask

    // Result side ready. One long hold-off is served on request; otherwise the receiver
    // stalls at random unless the no-idle stretch is on.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Every result beat is matched against the oldest owed beat, field by field.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (owed_beats.size() == 0) begin
                report_mismatch("result beat with nothing owed", m_sorted_value, 32'h0);
            end else begin
                if (m_sorted_value !== owed_beats[0].value) begin
                    report_mismatch("sorted_value", m_sorted_value, owed_beats[0].value);
                end
                if (m_last !== owed_beats[0].last) begin
                    report_mismatch("last", {31'b0, m_last}, {31'b0, owed_beats[0].last});
                end
                void'(owed_beats.pop_front());
            end
            beat_count++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        fill_t       fill;
        logic        order;
        logic [31:0] seed;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed sets. The first row relies on the order register's reset value; the
        // later ones flip it both ways.
        for (int r = 0; r < DIRECTED_SETS; r++) begin
            if (directed_sets[r].order != model_asc) begin
                write_order(directed_sets[r].order);
            end
            typed_fill  = directed_sets[r].typed;
            typed_value = directed_sets[r].seed;
            send_set(directed_sets[r].fill, directed_sets[r].seed);
        end
        typed_fill = 1'b0;

        // Random sets. The first runs into a long receiver hold-off, so the block sits
        // full while the next set is already being offered; that second set keeps the
        // order so that no register write waits for the drain. The second and third
        // sets run without any idling on either side.
        for (int k = 0; k < RANDOM_SETS; k++) begin
            order = (k == 1) ? model_asc : 1'($urandom_range(1));
            if (order != model_asc) begin
                write_order(order);
            end
            case ($urandom_range(9))
                0, 1, 2, 3: fill = FILL_RANDOM;
                4, 5:       fill = FILL_NARROW;
                6:          fill = FILL_CORNERS;
                7:          fill = FILL_RAMP_UP;
                8:          fill = FILL_ONE_HOT;
                default:    fill = FILL_FEW_KEYS;
            endcase
            seed = $urandom;
            if (k == 0) begin
                long_hold_req = 1'b1;
            end
            no_idle = (k == 1 || k == 2);
            send_set(fill, seed);
        end
        no_idle = 1'b0;
        s_valid <= 1'b0;

        while (owed_beats.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (owed_beats.size() != 0) begin
            report_mismatch("owed beats left over", owed_beats.size(), 32'h0);
        end

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
